/* design/hmr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmr_pkg
// Shared types, constants and helpers of the HTTP method recognizer: the
// built-in method names, their lengths and the result word carried along
// the row of match cells.
// ----------------------------------------------------------------------------
package hmr_pkg;

    localparam int NUM_NAMES  = 15;
    localparam int NAME_SLOTS = 10;
    localparam int CHAR_W     = 8;
    localparam int NAME_W     = NAME_SLOTS * CHAR_W;
    localparam int POS_W      = 4;
    localparam int CODE_W     = 4;

    localparam logic [POS_W-1:0]     POS_MAX     = 4'd15;
    localparam logic [CODE_W-1:0]    CODE_NONE   = 4'd15;
    localparam logic [NUM_NAMES-1:0] WEBDAV_MASK = 15'h7F00;

    localparam logic [CHAR_W-1:0] LOWER_A   = 8'h61;
    localparam logic [CHAR_W-1:0] LOWER_Z   = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_DIFF = 8'h20;

    // names are right aligned: the first character sits highest
    localparam logic [NAME_W-1:0] NAME_TEXT [NUM_NAMES] = '{
        NAME_W'("OPTIONS"),  NAME_W'("GET"),   NAME_W'("HEAD"),  NAME_W'("POST"),
        NAME_W'("PUT"),      NAME_W'("DELETE"), NAME_W'("TRACE"), NAME_W'("CONNECT"),
        NAME_W'("PROPFIND"), NAME_W'("PROPPATCH"), NAME_W'("COPY"), NAME_W'("MKCOL"),
        NAME_W'("MOVE"),     NAME_W'("LOCK"),  NAME_W'("UNLOCK")
    };

    localparam logic [POS_W-1:0] NAME_LEN [NUM_NAMES] = '{
        4'd7, 4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7,
        4'd8, 4'd9, 4'd4, 4'd5, 4'd4, 4'd4, 4'd6
    };

    // result word handed from cell to cell, lowest code wins
    typedef struct packed {
        logic              found;
        logic [CODE_W-1:0] code;
    } hmr_hit_t;

    // character of a name at a given token position, zero past its end
    function automatic logic [CHAR_W-1:0] name_byte(
        input logic [NAME_W-1:0] name,
        input logic [POS_W-1:0]  len,
        input logic [POS_W-1:0]  pos
    );
        logic [CHAR_W-1:0] r;
        r = '0;
        for (int j = 0; j < NAME_SLOTS; j++)
        begin
            if ((5'(pos) + 5'(j) + 5'd1) == 5'(len))
            begin
                r = name[CHAR_W*j +: CHAR_W];
            end
        end
        return r;
    endfunction

    // fold ascii lower case letters to upper case
    function automatic logic [CHAR_W-1:0] fold_upper(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/hmr_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmr_in_if
// Character channel: one byte of the method token per word, with a flag on
// the final byte.
// ----------------------------------------------------------------------------
interface hmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] name_char;
    logic       last_char;

    modport source (output valid, output name_char, output last_char, input ready);
    modport sink   (input valid, input name_char, input last_char, output ready);
endinterface
`default_nettype wire

/* design/hmr_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmr_out_if
// Result channel: one word per token, the recognized method code.
// ----------------------------------------------------------------------------
interface hmr_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [3:0] method_code;

    modport source (output valid, output found, output method_code, input ready);
    modport sink   (input valid, input found, input method_code, output ready);
endinterface
`default_nettype wire

/* design/hmr_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmr_cell
// Match cell for one method name. Tracks whether the token still agrees
// with the name and whether the whole name has been seen, and passes the
// lowest-code hit on to its neighbor.
// ----------------------------------------------------------------------------
module hmr_cell
    import hmr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 step,
    input  wire logic                 last,
    input  wire logic [CHAR_W-1:0]    ch,
    input  wire logic [POS_W-1:0]     pos,
    input  wire logic [NAME_W-1:0]    name,
    input  wire logic [POS_W-1:0]     len,
    input  wire logic [CODE_W-1:0]    code,
    input  wire logic                 allowed,
    input  wire hmr_hit_t             hit_in,
    output hmr_hit_t                  hit_out
);

    logic still_reg, still_next;
    logic full_reg, full_next;
    logic in_range, mismatch, at_end, full_now, hit;

    // compare this character against the name
    assign in_range = pos < len;
    assign mismatch = name_byte(name, len, pos) != ch;
    assign at_end   = (5'(pos) + 5'd1) == 5'(len);
    assign full_now = full_reg | (still_reg & in_range & ~mismatch & at_end);
    assign hit      = full_now & allowed;

    // lower codes sit earlier in the row and take priority
    always_comb
    begin
        hit_out = hit_in;
        if (!hit_in.found && hit)
        begin
            hit_out.found = 1'b1;
            hit_out.code  = code;
        end
    end

    // state update, cleared at the end of each token
    always_comb
    begin
        still_next = still_reg;
        full_next  = full_reg;
        if (step)
        begin
            if (last)
            begin
                still_next = 1'b1;
                full_next  = 1'b0;
            end
            else
            begin
                still_next = still_reg & ~(in_range & mismatch);
                full_next  = full_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            still_reg <= 1'b1;
            full_reg  <= 1'b0;
        end
        else
        begin
            still_reg <= still_next;
            full_reg  <= full_next;
        end
    end

endmodule
`default_nettype wire

/* design/http_method_recognizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// http_method_recognizer
// Recognizes an HTTP request method from its token, one character per word,
// case insensitive, using a row of match cells, one per method name.
// ----------------------------------------------------------------------------
//  channel   dir   word                      handshake
//  chars     in    name_char, last_char      valid / ready
//  result    out   found, method_code        valid / ready
//  cfg       in    webdav enable bit         cfg_wr_en, no wait
//
//  One character is taken every cycle unless a held result stalls the
//  channel until it is taken; a result taken in the same cycle lets the
//  next one through. The result of a token is registered in the cycle
//  after its last character is taken; the compare in the cells and the
//  priority ripple along the row are combinational. Reset clears the
//  position, the cells and the output register, and sets the webdav enable.
// ----------------------------------------------------------------------------
module http_method_recognizer
    import hmr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    hmr_in_if.sink      chars,
    hmr_out_if.source   result,
    input  wire logic   cfg_wr_en,
    input  wire logic   cfg_wr_data
);

    logic              webdav_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              found_reg;
    logic [CODE_W-1:0] code_reg;
    logic              step, load;
    logic [CHAR_W-1:0] ch;
    hmr_hit_t          chain [NUM_NAMES+1];

    // handshake
    assign chars.ready = !out_valid_reg || result.ready;
    assign step        = chars.valid && chars.ready;
    assign load        = step && chars.last_char;
    assign ch          = fold_upper(chars.name_char);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            webdav_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            webdav_reg <= cfg_wr_data;
        end
    end

    // token position, saturating
    always_comb
    begin
        pos_next = pos_reg;
        if (step)
        begin
            if (chars.last_char)
            begin
                pos_next = '0;
            end
            else if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    // row of match cells
    assign chain[0] = '{found: 1'b0, code: CODE_NONE};

    for (genvar i = 0; i < NUM_NAMES; i++)
    begin : g_cell
        hmr_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .step    (step),
            .last    (chars.last_char),
            .ch      (ch),
            .pos     (pos_reg),
            .name    (NAME_TEXT[i]),
            .len     (NAME_LEN[i]),
            .code    (CODE_W'(i)),
            .allowed (!WEBDAV_MASK[i] || webdav_reg),
            .hit_in  (chain[i]),
            .hit_out (chain[i+1])
        );
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            code_reg  <= CODE_NONE;
        end
        else if (load)
        begin
            found_reg <= chain[NUM_NAMES].found;
            code_reg  <= chain[NUM_NAMES].code;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.found       = found_reg;
    assign result.method_code = code_reg;

endmodule
`default_nettype wire

/* design/hmr_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hmr_checker
// Port-level checks of the HTTP method recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module hmr_checker
    import hmr_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              in_last,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              out_found,
    input wire logic [CODE_W-1:0] out_code
);

    // unsupported code exactly when nothing was found
    a_found_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_found != (out_code == CODE_NONE)))
        else $error("found flag disagrees with method code");

    // a new result only follows a final character
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
        else $error("result without a final character");

    // a held result blocks the character channel
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("character taken while result stalled");

    // a stalled result holds its word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_found) && $stable(out_code)))
        else $error("stalled result changed");

endmodule

bind http_method_recognizer hmr_checker u_hmr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .in_last   (chars.last_char),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_found (result.found),
    .out_code  (result.method_code)
);
`default_nettype wire

/* tb/tb_http_method_recognizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_http_method_recognizer
// Self-checking bench for the HTTP method recognizer. A table of directed
// tokens covers every method, case folding, short and long tokens, bytes
// outside the letters, and webdav enable changes (including mid-token).
// Random tokens follow: mostly real method names in mixed case, some with
// trailing bytes, plus truncated, corrupted and junk tokens. A scoreboard
// model tracks the match state per character and checks each result word.
// ----------------------------------------------------------------------------
module tb_http_method_recognizer;
    import hmr_pkg::*;

    localparam int METHOD_COUNT = 15;
    localparam int TEXT_MAX     = 20;
    localparam int RANDOM_CHARS = 650;
    localparam int CFG_SPACING  = 100;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT  = 200;

    typedef enum logic [3:0] {
        M_OPTIONS, M_GET, M_HEAD, M_POST, M_PUT, M_DELETE, M_TRACE, M_CONNECT,
        M_PROPFIND, M_PROPPATCH, M_COPY, M_MKCOL, M_MOVE, M_LOCK, M_UNLOCK, M_NONE
    } method_e;

    // method names, right aligned, first letter in the top byte
    localparam logic [71:0] METHOD_TEXT [METHOD_COUNT] = '{
        72'("OPTIONS"),  72'("GET"),       72'("HEAD"),  72'("POST"),
        72'("PUT"),      72'("DELETE"),    72'("TRACE"), 72'("CONNECT"),
        72'("PROPFIND"), 72'("PROPPATCH"), 72'("COPY"),  72'("MKCOL"),
        72'("MOVE"),     72'("LOCK"),      72'("UNLOCK")
    };

    localparam int METHOD_LEN [METHOD_COUNT] = '{
        7, 3, 4, 4, 3, 6, 5, 7, 8, 9, 4, 5, 4, 4, 6
    };

    // one directed token: text, register setting, optional mid-token write
    typedef struct packed {
        logic [8*TEXT_MAX-1:0] text;
        logic [4:0]            len;
        logic                  webdav;
        logic [4:0]            split;
        logic                  webdav_mid;
        logic                  typed;
        logic                  found;
        method_e               code;
    } probe_row_t;

    localparam int PROBE_COUNT = 28;

    localparam probe_row_t PROBES [PROBE_COUNT] = '{
        '{160'("GET"),       5'd3, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_GET},
        '{160'("get"),       5'd3, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_GET},
        '{160'("OPTIONS"),   5'd7, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_OPTIONS},
        '{160'("Head"),      5'd4, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_HEAD},
        '{160'("pOsT"),      5'd4, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_POST},
        '{160'("PUT"),       5'd3, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_PUT},
        '{160'("DELETE"),    5'd6, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_DELETE},
        '{160'("trace"),     5'd5, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_TRACE},
        '{160'("CONNECT"),   5'd7, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_CONNECT},
        '{160'("PROPFIND"),  5'd8, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_PROPFIND},
        '{160'("proppatch"), 5'd9, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_PROPPATCH},
        '{160'("COPY"),      5'd4, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_COPY},
        '{160'("MKCOL"),     5'd5, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_MKCOL},
        '{160'("move"),      5'd4, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_MOVE},
        '{160'("LOCK"),      5'd4, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_LOCK},
        '{160'("UNLOCK"),    5'd6, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_UNLOCK},
        // token shorter than any name it starts
        '{160'("GE"),        5'd2, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE},
        // extra bytes past a name are ignored
        '{160'("GETTER"),    5'd6, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_GET},
        // position saturates on a long token
        '{160'("PUTABCDEFGHIJKLMNOPQ"), 5'd20, 1'b1, 5'd0, 1'b0, 1'b1, 1'b1, M_PUT},
        // zero byte and bytes above 127 never match
        '{160'({8'h00}),              5'd1, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE},
        '{160'({"G", 8'h80, "T"}),    5'd3, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE},
        '{160'({8'hFF, "GET"}),       5'd4, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE},
        // webdav names masked off
        '{160'("PROPFIND"),  5'd8, 1'b0, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE},
        '{160'("copy"),      5'd4, 1'b0, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE},
        '{160'("PUT"),       5'd3, 1'b0, 5'd0, 1'b0, 1'b1, 1'b1, M_PUT},
        // register changed in mid-token, value at the final byte decides
        '{160'("MOVE"),      5'd4, 1'b0, 5'd3, 1'b1, 1'b0, 1'b0, M_NONE},
        '{160'("LOCK"),      5'd4, 1'b1, 5'd2, 1'b0, 1'b1, 1'b0, M_NONE},
        '{160'("X"),         5'd1, 1'b1, 5'd0, 1'b0, 1'b1, 1'b0, M_NONE}
    };

    // expectation typed into the table, taken instead of the model when set
    typedef struct packed {
        logic     typed;
        hmr_hit_t word;
    } pinned_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    hmr_in_if  chars_if();
    hmr_out_if result_if();

    http_method_recognizer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars_if),
        .result     (result_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // scoreboard model state
    logic [3:0]  tok_pos   = 4'd0;
    logic [14:0] tok_alive = '1;
    logic [14:0] tok_done  = '0;
    logic        webdav_on = 1'b1;

    hmr_hit_t     pending_methods [$];
    pinned_word_t pinned_methods [$];
    int           mismatches = 0;
    int           chars_sent = 0;
    bit           steady = 1'b0;
    logic         webdav_setting = 1'b1;

    function automatic logic [7:0] name_letter(input int idx, input int pos);
        return METHOD_TEXT[idx][8 * (METHOD_LEN[idx] - 1 - pos) +: 8];
    endfunction

    function automatic int draw_wait();
        return steady ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic void report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %0s", $time, msg);
    endfunction

    // advance the match state by one character, produce a word on the last
    function automatic void track_method_char(input logic [7:0] raw, input logic is_last,
                                              output logic emit, output hmr_hit_t word);
        logic [7:0]  c;
        logic [14:0] hits;
        c = (raw >= 8'h61 && raw <= 8'h7A) ? raw - 8'h20 : raw;
        emit = 1'b0;
        word = '{found: 1'b0, code: M_NONE};
        for (int i = 0; i < METHOD_COUNT; i++)
        begin
            if (tok_alive[i] && int'(tok_pos) < METHOD_LEN[i])
            begin
                if (name_letter(i, int'(tok_pos)) != c)
                    tok_alive[i] = 1'b0;
                else if (int'(tok_pos) + 1 == METHOD_LEN[i])
                    tok_done[i] = 1'b1;
            end
        end
        if (tok_pos != POS_MAX)
            tok_pos = tok_pos + 4'd1;
        if (is_last)
        begin
            hits = tok_done & (webdav_on ? {METHOD_COUNT{1'b1}} : ~WEBDAV_MASK);
            // lowest code wins
            for (int i = METHOD_COUNT - 1; i >= 0; i--)
            begin
                if (hits[i])
                    word = '{found: 1'b1, code: 4'(i)};
            end
            emit = 1'b1;
            tok_pos = 4'd0;
            tok_alive = '1;
            tok_done = '0;
        end
    endfunction

    // monitor: register writes, result words, accepted characters
    always @(posedge clk)
    begin : monitor
        logic         emit;
        hmr_hit_t     predicted;
        hmr_hit_t     want;
        pinned_word_t pin;
        if (rst_n)
        begin
            if (cfg_wr_en)
                webdav_on = cfg_wr_data;
            if (result_if.valid && result_if.ready)
            begin
                if (pending_methods.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected word: found %0b method_code %0d",
                                              result_if.found, result_if.method_code));
                end
                else
                begin
                    want = pending_methods.pop_front();
                    if (want.found !== result_if.found || want.code !== result_if.method_code)
                    begin
                        report_mismatch($sformatf(
                            "word mismatch: found exp %0b got %0b, method_code exp %0d got %0d",
                            want.found, result_if.found, want.code, result_if.method_code));
                    end
                end
            end
            if (chars_if.valid && chars_if.ready)
            begin
                track_method_char(chars_if.name_char, chars_if.last_char, emit, predicted);
                if (emit)
                begin
                    if (pinned_methods.size() != 0)
                    begin
                        pin = pinned_methods.pop_front();
                        if (pin.typed)
                            predicted = pin.word;
                    end
                    pending_methods.push_back(predicted);
                end
            end
        end
    end

    // result side: random stall before each word
    initial
    begin : result_sink
        int hold;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = draw_wait();
            repeat (hold)
            begin
                @(negedge clk);
                result_if.ready <= 1'b0;
            end
            @(negedge clk);
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_if.valid && result_if.ready));
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready)
                || cfg_wr_en)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // send one character word after a random gap
    task automatic send_char(input logic [7:0] c, input logic is_last);
        int gap;
        gap = draw_wait();
        repeat (gap)
        begin
            @(negedge clk);
            chars_if.valid <= 1'b0;
            chars_if.name_char <= 8'($urandom);
        end
        @(negedge clk);
        chars_if.valid <= 1'b1;
        chars_if.name_char <= c;
        chars_if.last_char <= is_last;
        do
            @(posedge clk);
        while (!(chars_if.valid && chars_if.ready));
        chars_sent++;
    endtask

    // write webdav enable once all expected words are in and the block settled
    task automatic write_webdav(input logic v);
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (pending_methods.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        webdav_setting = v;
    endtask

    // random token: mostly real names in mixed case, some broken or junk
    task automatic send_random_token();
        logic [7:0] tok [$];
        int kind;
        int idx;
        int n;
        kind = $urandom_range(0, 9);
        idx = $urandom_range(0, METHOD_COUNT - 1);
        if (kind <= 7)
        begin
            n = (kind == 6) ? $urandom_range(1, METHOD_LEN[idx] - 1) : METHOD_LEN[idx];
            for (int k = 0; k < n; k++)
                tok.push_back(name_letter(idx, k) | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
            if (kind == 7)
                tok[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
            if (kind <= 5)
            begin
                // trailing bytes, now and then long enough to saturate
                case ($urandom_range(0, 7))
                    0: n = $urandom_range(1, 3);
                    1: n = $urandom_range(4, 14);
                    default: n = 0;
                endcase
                for (int k = 0; k < n; k++)
                    tok.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind == 8)
        begin
            n = $urandom_range(1, 6);
            for (int k = 0; k < n; k++)
                tok.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            n = $urandom_range(1, 10);
            for (int k = 0; k < n; k++)
                tok.push_back(8'($urandom_range(65, 90)) | ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        end
        for (int k = 0; k < tok.size(); k++)
            send_char(tok[k], k == tok.size() - 1);
    endtask

    // stimulus
    initial
    begin
        int         tok_len;
        int         next_cfg;
        logic [7:0] ch;
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        chars_if.valid <= 1'b0;
        chars_if.name_char <= 8'h00;
        chars_if.last_char <= 1'b0;
        repeat (7)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int r = 0; r < PROBE_COUNT; r++)
        begin
            if (PROBES[r].webdav != webdav_setting)
                write_webdav(PROBES[r].webdav);
            pinned_methods.push_back('{typed: PROBES[r].typed,
                                       word: '{found: PROBES[r].found, code: PROBES[r].code}});
            tok_len = int'(PROBES[r].len);
            for (int k = 0; k < tok_len; k++)
            begin
                if (PROBES[r].split != 0 && k == int'(PROBES[r].split))
                    write_webdav(PROBES[r].webdav_mid);
                ch = PROBES[r].text[8 * (tok_len - 1 - k) +: 8];
                send_char(ch, k == tok_len - 1);
            end
        end

        // random tokens, register and idling mode changed every so often
        chars_sent = 0;
        next_cfg = 0;
        while (chars_sent < RANDOM_CHARS)
        begin
            if (chars_sent >= next_cfg)
            begin
                write_webdav(1'($urandom_range(0, 1)));
                steady = ($urandom_range(0, 3) == 0);
                next_cfg = next_cfg + CFG_SPACING;
            end
            send_random_token();
        end

        // drain
        @(negedge clk);
        chars_if.valid <= 1'b0;
        while (pending_methods.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0 && pending_methods.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
design/hmr_pkg.sv
design/hmr_in_if.sv
design/hmr_out_if.sv
design/hmr_cell.sv
design/http_method_recognizer.sv
design/hmr_checker.sv
tb/tb_http_method_recognizer.sv
